/* rtl/core/rcf_pkg.sv */
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types and codes for the route candidate filter: item op codes,
// field selectors, the captured item and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rcf_pkg;

	// item op codes
	localparam logic [2:0] OP_RESTART  = 3'd0;
	localparam logic [2:0] OP_WRITE    = 3'd1;
	localparam logic [2:0] OP_PRESENCE = 3'd2;
	localparam logic [2:0] OP_MATCH    = 3'd3;
	localparam logic [2:0] OP_FINALIZE = 3'd4;

	// field selectors
	localparam logic [1:0] FLD_METHOD = 2'd0;
	localparam logic [1:0] FLD_URI    = 2'd1;
	localparam logic [1:0] FLD_HOST   = 2'd2;

	localparam int FIELDS = 3;

	// widths fixed by the item format
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;
	localparam int MASK_W      = 16;

	// one input transaction, unpacked
	typedef struct packed {
		logic       present;
		logic [7:0] byte_value;
		logic [6:0] position;
		logic [1:0] field;
		logic [3:0] route;
		logic [2:0] op;
	} item_t;

	// controller to datapath
	typedef struct packed {
		logic clear;    // clearing sweep writes one row
		logic capture;  // latch the accepted item
		logic exec;     // table write / presence set / table read
		logic update;   // candidate update and result load
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done; // last row being cleared
		logic out_free;   // result register can take a new result
	} dp_status_t;

endpackage

/* rtl/core/route_candidate_filter_top.sv */
// ----------------------------------------------------------------------------
// route_candidate_filter_top
// Route candidate filter: route string table with per-route candidate bits.
// ----------------------------------------------------------------------------
// Each input transaction produces exactly one result transaction holding the
// candidate mask after the item. An item goes through accept, table access
// (the registered read of the route table memory) and candidate update; a
// stalled result holds the update. A new item is taken while the last result
// still waits on the output register. After reset all 3*MAX_LEN table rows
// are swept to zero, one row per cycle, with s_tready low.
module route_candidate_filter_top
	import rcf_pkg::*;
#(
	parameter int ROUTES  = 16,
	parameter int MAX_LEN = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// op[2:0], route[6:3], field[8:7], position[15:9], byte_value[23:16],
	// present[24], zero fill [31:25]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// candidate_mask[15:0], any_left[16], zero fill [23:17]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	// sequencer
	rcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// table and candidate datapath
	rcf_datapath #(
		.ROUTES  (ROUTES),
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* rtl/core/rcf_ctrl.sv */
// ----------------------------------------------------------------------------
// rcf_ctrl
// Sequencer for the route candidate filter: clearing sweep after reset,
// then accept / execute / update for each item.
// ----------------------------------------------------------------------------
module rcf_ctrl
	import rcf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   ready_q;

	// state and ready register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (status.clear_done) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_tvalid && ready_q) begin
						state_q <= ST_EXEC;
						ready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					// hold until the result register is free
					if (status.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign s_tready = ready_q;

	// commands
	always_comb begin
		cmd         = '0;
		cmd.clear   = (state_q == ST_CLEAR);
		cmd.capture = ready_q && s_tvalid;
		cmd.exec    = (state_q == ST_EXEC);
		cmd.update  = (state_q == ST_UPDATE) && status.out_free;
	end

endmodule

/* rtl/core/rcf_datapath.sv */
// ----------------------------------------------------------------------------
// rcf_datapath
// Route table (one byte lane memory per route), presence flags, candidate
// bits and the result register.
// ----------------------------------------------------------------------------
module rcf_datapath
	import rcf_pkg::*;
#(
	parameter int ROUTES  = 16,
	parameter int MAX_LEN = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  ctl_cmd_t               cmd,
	output dp_status_t             status,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int ROWS = FIELDS * MAX_LEN;
	localparam int AW   = $clog2(ROWS);

	item_t             item_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     addr;
	logic              pos_ok;
	logic              fld_ok;
	logic [2:0]        fld_onehot;
	logic [7:0]        rd_q [ROUTES];
	logic [2:0]        present_q [ROUTES];
	logic [ROUTES-1:0] cand_q;
	logic [ROUTES-1:0] cand_next;
	logic [MASK_W-1:0] mask_q;
	logic              any_q;
	logic              m_tvalid_q;
	logic [ROUTES+MASK_W-1:0] cand_pad;

	// item capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_t'(s_tdata[$bits(item_t)-1:0]);
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear && !status.clear_done) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// table row address: field base plus byte offset
	always_comb begin
		fld_onehot = 3'b000;
		addr       = AW'(item_q.position);
		case (item_q.field)
			FLD_METHOD: fld_onehot = 3'b001;
			FLD_URI: begin
				fld_onehot = 3'b010;
				addr       = AW'(MAX_LEN) + AW'(item_q.position);
			end
			FLD_HOST: begin
				fld_onehot = 3'b100;
				addr       = AW'(2 * MAX_LEN) + AW'(item_q.position);
			end
			default: fld_onehot = 3'b000;
		endcase
	end

	assign fld_ok = |fld_onehot;
	assign pos_ok = 9'(item_q.position) < 9'(MAX_LEN);

	// one lane per route: byte memory, presence flags, candidate logic
	for (genvar r = 0; r < ROUTES; r++) begin : g_lane
		logic [7:0] mem [ROWS];
		logic [7:0] rbyte;
		logic       sel;
		logic       fpres;

		assign sel = (7'(item_q.route) == 7'(r));

		always_ff @(posedge clk) begin
			if (cmd.clear) begin
				mem[clr_q] <= 8'h00;
			end else if (cmd.exec && item_q.op == OP_WRITE && sel && fld_ok && pos_ok) begin
				mem[addr] <= item_q.byte_value;
			end
			if (cmd.exec) begin
				rd_q[r] <= mem[addr];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				present_q[r] <= 3'b000;
			end else if (cmd.exec && item_q.op == OP_PRESENCE && sel) begin
				if (item_q.present) begin
					present_q[r] <= present_q[r] | fld_onehot;
				end else begin
					present_q[r] <= present_q[r] & ~fld_onehot;
				end
			end
		end

		// positions at or past MAX_LEN read as zero
		assign rbyte = pos_ok ? rd_q[r] : 8'h00;
		assign fpres = |(present_q[r] & fld_onehot);

		always_comb begin
			case (item_q.op)
				OP_RESTART: cand_next[r] = 1'b1;
				OP_MATCH: cand_next[r] = cand_q[r] && fpres && (rbyte == item_q.byte_value);
				OP_FINALIZE: cand_next[r] = cand_q[r] && !(fpres && (rbyte != 8'h00));
				default: cand_next[r] = cand_q[r];
			endcase
		end
	end

	// candidate bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q     <= '1;
			m_tvalid_q <= 1'b0;
		end else if (cmd.update) begin
			cand_q     <= cand_next;
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// visible mask covers routes 0..15, zero at and above ROUTES
	assign cand_pad = {{MASK_W{1'b0}}, cand_next};

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mask_q <= cand_pad[MASK_W-1:0];
			any_q  <= |cand_next;
		end
	end

	assign status.clear_done = cmd.clear && (clr_q == AW'(ROWS - 1));
	assign status.out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - MASK_W - 1){1'b0}}, any_q, mask_q};

endmodule

/* bench/tb_route_candidate_filter_top.sv */
// ----------------------------------------------------------------------------
// tb_route_candidate_filter_top
// Self-checking bench for the route candidate filter. Items are streamed in
// from a queue and each accepted item is run through a local model of the
// route table and candidate bits. Every result transaction is compared field
// by field with the oldest predicted mask. Stimulus is a short directed run
// over the corner cases, then route loads and request parses with random
// content, mixed with unconstrained noise items. Both sides idle in bursts.
// ----------------------------------------------------------------------------
module tb_route_candidate_filter_top;
	import rcf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROUTES     = 16;
	localparam int MAX_LEN    = 64;
	localparam int ITEM_GOAL  = 1450;
	localparam int QUIET_TAIL = 150;
	localparam int STALL_MAX  = 18;
	localparam int WDOG_LIMIT = 4000;
	localparam int DRAIN_WAIT = 12;

	// codes the package leaves unnamed
	localparam logic [1:0] FLD_NONE  = 2'd3;
	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_TOP    = 3'd7;

	typedef struct {
		logic [MASK_W-1:0] mask;
		logic              any;
	} verdict_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	route_candidate_filter_top #(
		.ROUTES (ROUTES),
		.MAX_LEN(MAX_LEN)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// stimulus plan and expectations
	item_t    pend_items[$];
	verdict_t mask_due[$];
	item_t    cur_item;
	logic     plan_done = 1'b0;
	int       errors    = 0;
	int       items_in  = 0;
	int       results   = 0;
	int       match_cnt = 0;
	int       finals    = 0;
	int       final_hits = 0;

	// model state
	logic [ROUTES-1:0] cand_bits;
	logic [7:0]        text_mem [ROUTES][FIELDS][MAX_LEN];
	logic [FIELDS-1:0] fld_on   [ROUTES];

	// what the stimulus side believes is loaded, used to build requests
	logic [7:0]        plan_text [ROUTES][FIELDS][MAX_LEN];
	logic [FIELDS-1:0] plan_on   [ROUTES];

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Model of the filter
	// ------------------------------------------------------------------------
	function automatic logic [7:0] stored_byte(int r, int f, int pos);
		if (f >= FIELDS || pos >= MAX_LEN)
			return 8'd0;
		return text_mem[r][f][pos];
	endfunction

	task automatic clear_model();
		cand_bits = '1;
		for (int r = 0; r < ROUTES; r++) begin
			fld_on[r]  = '0;
			plan_on[r] = '0;
			for (int f = 0; f < FIELDS; f++)
				for (int p = 0; p < MAX_LEN; p++) begin
					text_mem[r][f][p]  = 8'd0;
					plan_text[r][f][p] = 8'd0;
				end
		end
	endtask

	// apply one item and return the mask after it
	function automatic verdict_t filter_item(item_t it);
		verdict_t v;
		int       f;
		int       pos;
		f   = it.field;
		pos = it.position;
		case (it.op)
			OP_RESTART: cand_bits = '1;
			OP_WRITE: begin
				if (f < FIELDS && pos < MAX_LEN)
					text_mem[it.route][f][pos] = it.byte_value;
			end
			OP_PRESENCE: begin
				if (f < FIELDS)
					fld_on[it.route][f] = it.present;
			end
			OP_MATCH: begin
				for (int r = 0; r < ROUTES; r++)
					if (cand_bits[r] && (f >= FIELDS || !fld_on[r][f] ||
							stored_byte(r, f, pos) != it.byte_value))
						cand_bits[r] = 1'b0;
			end
			OP_FINALIZE: begin
				if (f < FIELDS)
					for (int r = 0; r < ROUTES; r++)
						if (cand_bits[r] && fld_on[r][f] && stored_byte(r, f, pos) != 8'd0)
							cand_bits[r] = 1'b0;
			end
			default: ;
		endcase
		v.mask = cand_bits;
		v.any  = |cand_bits;
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------------
	task automatic queue_item(logic [2:0] op, int route, int field, int pos,
			int bval, logic pres);
		item_t it;
		it.op         = op;
		it.route      = route[3:0];
		it.field      = field[1:0];
		it.position   = pos[6:0];
		it.byte_value = bval[7:0];
		it.present    = pres;
		pend_items.push_back(it);
	endtask

	task automatic queue_noise();
		logic [2:0] op;
		op = $urandom_range(0, 9) < 8 ? 3'($urandom_range(0, OP_FINALIZE)) :
			3'($urandom_range(0, OP_TOP));
		queue_item(op, $urandom_range(0, 15), $urandom_range(0, 3),
			$urandom_range(0, 127), $urandom_range(0, 255), 1'($urandom));
	endtask

	// mostly a small alphabet so routes share prefixes
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0: return "G";
			1: return "E";
			2: return "T";
			3: return "/";
			4: return "a";
			5: return "b";
			6: return ".";
			7: return "P";
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	// write one field string of a route, its terminator (when shorter than MAX_LEN) and its presence flag
	task automatic queue_route_load(int r, int f);
		int         len;
		logic [7:0] c;
		logic       pres;
		case ($urandom_range(0, 15))
			0: len = MAX_LEN;
			1: len = $urandom_range(7, MAX_LEN - 1);
			2: len = 0;
			default: len = $urandom_range(1, 6);
		endcase
		for (int p = 0; p < len; p++) begin
			c = pick_char();
			plan_text[r][f][p] = c;
			queue_item(OP_WRITE, r, f, p, c, 1'($urandom));
		end
		if (len < MAX_LEN) begin
			plan_text[r][f][len] = 8'd0;
			queue_item(OP_WRITE, r, f, len, 0, 1'($urandom));
		end
		pres = $urandom_range(0, 7) != 0;
		plan_on[r][f] = pres;
		queue_item(OP_PRESENCE, r, f, $urandom_range(0, 127), $urandom_range(0, 255), pres);
	endtask

	// restart, then match fields of a target route that may change between fields, sometimes spoiled
	task automatic queue_request();
		int         t;
		int         len;
		int         flip;
		int         tok;
		logic [7:0] c;
		queue_item(OP_RESTART, $urandom_range(0, 15), $urandom_range(0, 3),
			$urandom_range(0, 127), $urandom_range(0, 255), 1'($urandom));
		t = $urandom_range(0, ROUTES - 1);
		for (int f = 0; f < FIELDS; f++) begin
			if ($urandom_range(0, 4) == 0)
				continue;
			if ($urandom_range(0, 5) == 0)
				t = $urandom_range(0, ROUTES - 1);
			len = 0;
			while (len < MAX_LEN && plan_text[t][f][len] != 8'd0)
				len++;
			flip = $urandom_range(0, 7) == 0 ? $urandom_range(0, len) : -1;
			for (int p = 0; p < len; p++) begin
				c = plan_text[t][f][p];
				if (p == flip)
					c = c ^ (8'd1 << $urandom_range(0, 7));
				queue_item(OP_MATCH, $urandom_range(0, 15), f, p, c, 1'($urandom));
			end
			tok = len;
			if ($urandom_range(0, 7) == 0)
				tok = $urandom_range(0, 1) ? len + 1 : (len > 0 ? len - 1 : 0);
			queue_item(OP_FINALIZE, $urandom_range(0, 15), f, tok,
				$urandom_range(0, 255), 1'($urandom));
		end
	endtask

	task automatic queue_random_until(int goal);
		while (pend_items.size() + items_in < goal) begin
			case ($urandom_range(0, 7))
				0, 1: queue_route_load($urandom_range(0, ROUTES - 1), $urandom_range(0, 2));
				2, 3, 4, 5: queue_request();
				default: queue_noise();
			endcase
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pend_items.size() != 0 || s_tvalid || mask_due.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Input driver
	// ------------------------------------------------------------------------
	int tx_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		int       idle_pct;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			tx_gap   = 0;
		end else begin
			// transaction accepted at this edge
			if (s_tvalid && s_tready) begin
				v = filter_item(cur_item);
				mask_due.push_back(v);
				items_in++;
				if (cur_item.op == OP_MATCH)
					match_cnt++;
				if (cur_item.op == OP_FINALIZE) begin
					finals++;
					if (v.any)
						final_hits++;
				end
				idle_pct = (plan_done && pend_items.size() < QUIET_TAIL) ? 0 :
					((items_in / 80) % 3 == 0 ? 0 : ((items_in / 80) % 3 == 1 ? 12 : 40));
				if ($urandom_range(0, 99) < idle_pct)
					tx_gap = $urandom_range(1, STALL_MAX);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pend_items.size() != 0) begin
					cur_item = pend_items.pop_front();
					s_tdata  <= IN_TDATA_W'(cur_item);
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor and checker
	// ------------------------------------------------------------------------
	int rx_stall = 0;

	always @(posedge clk or negedge arst_n) begin
		verdict_t exp_v;
		int       stall_pct;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results++;
				if (mask_due.size() == 0) begin
					$error("result with no item outstanding: mask %h any_left %b",
						m_tdata[MASK_W-1:0], m_tdata[MASK_W]);
					errors++;
				end else begin
					exp_v = mask_due.pop_front();
					if (m_tdata[MASK_W-1:0] !== exp_v.mask) begin
						$error("candidate_mask: expected %h, got %h", exp_v.mask,
							m_tdata[MASK_W-1:0]);
						errors++;
					end
					if (m_tdata[MASK_W] !== exp_v.any) begin
						$error("any_left: expected %b, got %b", exp_v.any, m_tdata[MASK_W]);
						errors++;
					end
				end
			end
			// receiver back-pressure, in bursts
			stall_pct = (plan_done && pend_items.size() < QUIET_TAIL) ? 0 :
				((results / 70 + 1) % 3 == 0 ? 0 : ((results / 70 + 1) % 3 == 1 ? 10 : 35));
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				rx_stall = $urandom_range(0, STALL_MAX - 1);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: cycles without any transaction on either side
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("timeout: %0d items pending, %0d results outstanding",
				pend_items.size(), mask_due.size());
			$display("tb_route_candidate_filter_top: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		clear_model();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corner cases
		queue_item(OP_MATCH, 0, FLD_METHOD, 0, 0, 1'b0);           // no field present anywhere
		queue_item(OP_RESTART, 15, FLD_NONE, 127, 255, 1'b1);
		queue_item(OP_WRITE, 0, FLD_METHOD, 0, "G", 1'b0);
		queue_item(OP_WRITE, 0, FLD_METHOD, 1, "E", 1'b0);
		queue_item(OP_WRITE, 0, FLD_METHOD, 2, "T", 1'b0);
		queue_item(OP_WRITE, 15, FLD_METHOD, 0, "G", 1'b1);
		queue_item(OP_WRITE, 1, FLD_METHOD, MAX_LEN, 255, 1'b0);  // past the string: dropped
		queue_item(OP_WRITE, 15, FLD_HOST, 127, 170, 1'b0);
		queue_item(OP_WRITE, 2, FLD_NONE, 0, 85, 1'b0);           // no such field: dropped
		queue_item(OP_WRITE, 15, FLD_HOST, MAX_LEN - 1, 255, 1'b0);
		queue_item(OP_PRESENCE, 0, FLD_METHOD, 0, 0, 1'b1);
		queue_item(OP_PRESENCE, 15, FLD_METHOD, 127, 255, 1'b1);
		queue_item(OP_PRESENCE, 3, FLD_NONE, 0, 0, 1'b1);
		queue_item(OP_MATCH, 9, FLD_METHOD, 0, "G", 1'b0);
		queue_item(OP_MATCH, 9, FLD_METHOD, 1, "E", 1'b0);
		queue_item(OP_MATCH, 9, FLD_METHOD, 2, "T", 1'b0);
		queue_item(OP_FINALIZE, 9, FLD_METHOD, 3, 0, 1'b0);
		queue_item(OP_SPARE5, 15, FLD_HOST, 127, 255, 1'b1);
		queue_item(OP_SPARE6, 0, FLD_METHOD, 0, 0, 1'b0);
		queue_item(OP_TOP, 7, FLD_URI, 64, 128, 1'b1);
		queue_item(OP_MATCH, 0, FLD_METHOD, 100, 0, 1'b0);        // beyond the string reads zero
		queue_item(OP_FINALIZE, 0, FLD_NONE, 0, 0, 1'b0);
		queue_item(OP_RESTART, 0, FLD_METHOD, 0, 0, 1'b0);
		queue_item(OP_FINALIZE, 0, FLD_METHOD, 1, 0, 1'b0);       // long string dropped, absent kept
		queue_item(OP_MATCH, 0, FLD_NONE, 5, 0, 1'b0);            // no field to compare: all dropped
		queue_item(OP_RESTART, 0, FLD_URI, 0, 0, 1'b0);
		queue_item(OP_MATCH, 0, FLD_URI, 70, 85, 1'b0);
		queue_item(OP_PRESENCE, 15, FLD_METHOD, 0, 0, 1'b0);
		wait_idle();

		// load a random three quarters of the route fields, then mixed traffic
		for (int r = 0; r < ROUTES; r++)
			for (int f = 0; f < FIELDS; f++)
				if ($urandom_range(0, 3) != 0)
					queue_route_load(r, f);
		queue_random_until(ITEM_GOAL / 2);

		// sender holds off until the block has drained
		wait_idle();
		queue_random_until(ITEM_GOAL);
		plan_done = 1'b1;
		wait_idle();
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("%0d items, %0d results checked: %0d byte matches, %0d finalizes",
			items_in, results, match_cnt, finals);
		$display("%0d finalizes still had a live route", final_hits);
		if (errors == 0)
			$display("tb_route_candidate_filter_top: PASS");
		else
			$display("tb_route_candidate_filter_top: FAIL");
		$finish;
	end

endmodule
